### hw/rtl/nearest_landmark_matcher_assert.svh
// assertion macros for the matcher rtl
`ifndef NEAREST_LANDMARK_MATCHER_ASSERT_SVH
`define NEAREST_LANDMARK_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define NLM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nlm assertion failed");
`define NLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlm assertion failed");
`else
`define NLM_ASSERT(lbl, prop)
`define NLM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/nlm_pkg.sv
`default_nettype none
package nlm_pkg;

  localparam int MAX_LANDMARKS_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int COORD_W  = 24;
  localparam int MAG_W    = 24;
  localparam int SQ_W     = 48;
  localparam int DIST_W   = 49;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
  } dist_res_t;

endpackage
`default_nettype wire

### hw/rtl/nlm_table.sv
`default_nettype none
module nlm_table #(
  parameter int MAX_LANDMARKS = nlm_pkg::MAX_LANDMARKS_DEF,
  parameter int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire nlm_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output nlm_pkg::entry_t      rdata_r
);

  nlm_pkg::entry_t mem [MAX_LANDMARKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/nlm_dist.sv
`default_nettype none
module nlm_dist (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire nlm_pkg::tag_t                     tag,
  input  wire nlm_pkg::entry_t                   ent,
  input  wire logic signed [nlm_pkg::COORD_W-1:0] obs_x,
  input  wire logic signed [nlm_pkg::COORD_W-1:0] obs_y,
  output nlm_pkg::dist_res_t                     res
);

  // stage 1: differences and magnitudes
  logic signed [nlm_pkg::COORD_W:0] dx;
  logic signed [nlm_pkg::COORD_W:0] dy;
  logic [nlm_pkg::COORD_W:0]        adx;
  logic [nlm_pkg::COORD_W:0]        ady;

  nlm_pkg::tag_t                 s1_tag_r;
  logic [nlm_pkg::ID_W-1:0]      s1_id_r;
  logic [nlm_pkg::MAG_W-1:0]     s1_mx_r;
  logic [nlm_pkg::MAG_W-1:0]     s1_my_r;

  nlm_pkg::tag_t                 s2_tag_r;
  logic [nlm_pkg::ID_W-1:0]      s2_id_r;
  logic [nlm_pkg::SQ_W-1:0]      s2_sqx_r;
  logic [nlm_pkg::SQ_W-1:0]      s2_sqy_r;

  nlm_pkg::tag_t                 s3_tag_r;
  logic [nlm_pkg::ID_W-1:0]      s3_id_r;
  logic [nlm_pkg::DIST_W-1:0]    s3_dist_r;

  always_comb begin
    dx  = {obs_x[nlm_pkg::COORD_W-1], obs_x} - {ent.x[nlm_pkg::COORD_W-1], ent.x};
    dy  = {obs_y[nlm_pkg::COORD_W-1], obs_y} - {ent.y[nlm_pkg::COORD_W-1], ent.y};
    adx = dx[nlm_pkg::COORD_W] ? (~dx + 1'b1) : dx;
    ady = dy[nlm_pkg::COORD_W] ? (~dy + 1'b1) : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_id_r   <= ent.id;
    s1_mx_r   <= adx[nlm_pkg::MAG_W-1:0];
    s1_my_r   <= ady[nlm_pkg::MAG_W-1:0];
    s2_id_r   <= s1_id_r;
    s2_sqx_r  <= s1_mx_r * s1_mx_r;
    s2_sqy_r  <= s1_my_r * s1_my_r;
    s3_id_r   <= s2_id_r;
    s3_dist_r <= {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
  end

  assign res.vld  = s3_tag_r.vld;
  assign res.last = s3_tag_r.last;
  assign res.id   = s3_id_r;
  assign res.dsq  = s3_dist_r;

endmodule
`default_nettype wire

### hw/rtl/nearest_landmark_matcher.sv
// Nearest landmark matcher. Pulse start with an item while busy is low. Clear,
// load and unused actions finish at once: busy stays low and out_valid pulses
// in the next cycle. A query on a table of N landmarks holds busy while the
// table memory is read one entry per cycle and every entry passes through
// the shared distance pipeline (difference, squares, sum) before the running
// minimum compare; out_valid pulses in the same cycle that busy falls. A
// query on an empty table finishes at once with status no match. Each result
// is shown for exactly one cycle and the receiver cannot stall it, so it must
// take out_valid whenever it rises.
`default_nettype none
`include "nearest_landmark_matcher_assert.svh"
module nearest_landmark_matcher #(
  parameter int MAX_LANDMARKS = nlm_pkg::MAX_LANDMARKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [nlm_pkg::ACTION_W-1:0]       in_action,
  input  wire logic [nlm_pkg::ID_W-1:0]           in_landmark_id,
  input  wire logic signed [nlm_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic signed [nlm_pkg::COORD_W-1:0] in_coord_y,
  output logic                                    out_valid,
  output logic [nlm_pkg::STATUS_W-1:0]            out_status,
  output logic [nlm_pkg::ID_W-1:0]                out_match_id,
  output logic [nlm_pkg::DIST_W-1:0]              out_best_distance_sq
);

  localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CW = $clog2(MAX_LANDMARKS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic have_r, have_nxt;
  logic [nlm_pkg::DIST_W-1:0] best_r, best_nxt;
  logic [nlm_pkg::ID_W-1:0] best_id_r, best_id_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [nlm_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [nlm_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic [nlm_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic signed [nlm_pkg::COORD_W-1:0] obs_x_r;
  logic signed [nlm_pkg::COORD_W-1:0] obs_y_r;
  nlm_pkg::tag_t tag_r, tag_nxt;

  logic accept;
  logic full;
  logic we;
  logic take;
  nlm_pkg::entry_t wdata;
  nlm_pkg::entry_t rdata;
  nlm_pkg::dist_res_t res;

  assign busy   = (state_r == S_SCAN);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(MAX_LANDMARKS));

  assign wdata.id = in_landmark_id;
  assign wdata.x  = in_coord_x;
  assign wdata.y  = in_coord_y;

  nlm_table #(
    .MAX_LANDMARKS(MAX_LANDMARKS),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .we(we),
    .waddr(count_r[AW-1:0]),
    .wdata(wdata),
    .raddr(idx_r[AW-1:0]),
    .rdata_r(rdata)
  );

  nlm_dist u_dist (
    .clk(clk),
    .rst_n(rst_n),
    .tag(tag_r),
    .ent(rdata),
    .obs_x(obs_x_r),
    .obs_y(obs_y_r),
    .res(res)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    best_id_nxt    = best_id_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_dist_nxt   = out_dist_r;
    tag_nxt        = '0;
    we             = 1'b0;
    take           = 1'b0;

    if (accept) begin
      out_status_nxt = nlm_pkg::ST_OK;
      out_id_nxt     = '0;
      out_dist_nxt   = '0;
      case (in_action)
        nlm_pkg::ACT_CLEAR: begin
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
        end
        nlm_pkg::ACT_LOAD: begin
          if (full) begin
            out_status_nxt = nlm_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
        end
        nlm_pkg::ACT_QUERY: begin
          if (count_r == '0) begin
            out_status_nxt = nlm_pkg::ST_NO_MATCH;
            out_valid_nxt  = 1'b1;
          end else begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
            have_nxt  = 1'b0;
          end
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end

    if (state_r == S_SCAN) begin
      // walk the table one entry a cycle
      if (idx_r != count_r) begin
        tag_nxt.vld  = 1'b1;
        tag_nxt.last = (idx_r == count_r - CW'(1));
        idx_nxt      = idx_r + 1'b1;
      end
      // running minimum, strict less-than keeps the earliest entry on a tie
      if (res.vld) begin
        take = !have_r || (res.dsq < best_r);
        if (take) begin
          best_nxt    = res.dsq;
          best_id_nxt = res.id;
        end
        have_nxt = 1'b1;
        if (res.last) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = nlm_pkg::ST_OK;
          out_id_nxt     = take ? res.id : best_id_r;
          out_dist_nxt   = take ? res.dsq : best_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      tag_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r       <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    best_id_r    <= best_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_dist_r   <= out_dist_nxt;
    if (accept) begin
      obs_x_r <= in_coord_x;
      obs_y_r <= in_coord_y;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_match_id         = out_id_r;
  assign out_best_distance_sq = out_dist_r;

  `NLM_ASSERT(a_count_bound, count_r <= CW'(MAX_LANDMARKS))
  `NLM_ASSERT(a_done_strobe, $fell(busy) |-> out_valid)
  `NLM_ASSERT(a_res_in_scan, res.vld |-> (state_r == S_SCAN))
  `NLM_ASSERT(a_fail_zero, (out_valid && (out_status != nlm_pkg::ST_OK)) |-> ((out_match_id == '0) && (out_best_distance_sq == '0)))
  `NLM_ASSERT_NEXT(a_query_scan, accept && (in_action == nlm_pkg::ACT_QUERY) && (count_r != '0), busy && !out_valid)

endmodule
`default_nettype wire

### test/nearest_landmark_matcher_tb.sv
`default_nettype none
module nearest_landmark_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nlm_pkg::*;

  localparam int DEPTH = MAX_LANDMARKS_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int                        idle_pct;
    bit                        hold;
  } stim_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [DIST_W-1:0]   dsq;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [ACTION_W-1:0] in_action = ACT_CLEAR;
  logic [ID_W-1:0] in_landmark_id = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic busy;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0] out_match_id;
  logic [DIST_W-1:0] out_best_distance_sq;

  nearest_landmark_matcher uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_landmark_id      (in_landmark_id),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_match_id        (out_match_id),
    .out_best_distance_sq(out_best_distance_sq)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // landmark table as the block should hold it
  logic signed [COORD_W-1:0] lm_x [DEPTH];
  logic signed [COORD_W-1:0] lm_y [DEPTH];
  logic [ID_W-1:0] lm_id [DEPTH];
  int lm_count = 0;

  stim_t pending[$];
  match_t expected_matches[$];
  stim_t cur;
  match_t pred;
  match_t seen;
  logic slot_free;
  logic go;
  int fails = 0;
  int n_items = 0;
  int n_matched = 0;
  int n_empty = 0;
  int n_dropped = 0;

  // stimulus generator state
  int phase_idle = 0;
  logic [COORD_W-1:0] gen_x [DEPTH];
  logic [COORD_W-1:0] gen_y [DEPTH];
  int gen_n = 0;

  function automatic match_t nearest_match(input stim_t s);
    match_t r;
    longint dx;
    longint dy;
    longint d;
    longint best;
    r.status = ST_OK;
    r.id = '0;
    r.dsq = '0;
    best = 0;
    case (s.action)
      ACT_CLEAR: lm_count = 0;
      ACT_LOAD: begin
        if (lm_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lm_x[lm_count] = s.x;
          lm_y[lm_count] = s.y;
          lm_id[lm_count] = s.id;
          lm_count++;
        end
      end
      ACT_QUERY: begin
        if (lm_count == 0) begin
          r.status = ST_NO_MATCH;
        end else begin
          for (int i = 0; i < lm_count; i++) begin
            dx = longint'(s.x) - longint'(lm_x[i]);
            dy = longint'(s.y) - longint'(lm_y[i]);
            d = dx * dx + dy * dy;
            if (i == 0 || d < best) begin
              best = d;
              r.id = lm_id[i];
            end
          end
          r.dsq = best[DIST_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add(input logic [ACTION_W-1:0] a, input logic [ID_W-1:0] id,
                     input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    stim_t s;
    s.action = a;
    s.id = id;
    s.x = x;
    s.y = y;
    s.idle_pct = phase_idle;
    s.hold = 1'b0;
    pending = {pending, s};
  endtask

  task automatic add_hold();
    stim_t s;
    s.action = ACT_UNUSED;
    s.id = '0;
    s.x = '0;
    s.y = '0;
    s.idle_pct = 0;
    s.hold = 1'b1;
    pending = {pending, s};
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input bit tight);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return C_MAX;
    if (r == 1) return C_MIN;
    if (tight) return COORD_W'($urandom_range(0, 8191) - 4096);
    return COORD_W'($urandom());
  endfunction

  task automatic load_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    add(ACT_LOAD, ID_W'($urandom()), x, y);
    if (gen_n < DEPTH) begin
      gen_x[gen_n] = x;
      gen_y[gen_n] = y;
      gen_n++;
    end
  endtask

  // usually a clear, a run of loads, then queries with some noise mixed in
  task automatic gen_sequence();
    int r;
    int j;
    int nload;
    int nq;
    bit tight;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    if ($urandom_range(0, 99) < 85) begin
      add(ACT_CLEAR, ID_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
      gen_n = 0;
    end
    tight = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 19);
    if (r == 0) nload = 0;
    else if (r <= 2) nload = $urandom_range(56, 70);
    else nload = $urandom_range(1, 8);
    for (int k = 0; k < nload; k++) begin
      if (gen_n > 0 && $urandom_range(0, 4) == 0) begin
        j = $urandom_range(0, gen_n - 1);
        load_point(gen_x[j], gen_y[j]);
      end else begin
        load_point(pick_coord(tight), pick_coord(tight));
      end
    end
    nq = $urandom_range(1, 6);
    for (int k = 0; k < nq; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add(ACT_UNUSED, ID_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (r < 12) begin
        load_point(pick_coord(tight), pick_coord(tight));
      end else begin
        if (gen_n > 0 && r < 60) begin
          j = $urandom_range(0, gen_n - 1);
          qx = gen_x[j] + COORD_W'($urandom_range(0, 31) - 16);
          qy = gen_y[j] + COORD_W'($urandom_range(0, 31) - 16);
        end else begin
          qx = pick_coord(tight);
          qy = pick_coord(tight);
        end
        add(ACT_QUERY, ID_W'($urandom()), qx, qy);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      slot_free = 1'b1;
      if (start) begin
        if (!busy) begin
          pred = nearest_match(cur);
          expected_matches = {expected_matches, pred};
          n_items++;
        end else begin
          slot_free = 1'b0;
        end
      end
      if (slot_free) begin
        go = 1'b0;
        if (pending.size() > 0) begin
          if (pending[0].hold) begin
            if (expected_matches.size() == 0 && !out_valid && !busy) begin
              void'(pending.pop_front());
            end
          end else if ($urandom_range(0, 99) >= pending[0].idle_pct) begin
            cur = pending.pop_front();
            go = 1'b1;
          end
        end
        start <= go;
        if (go) begin
          in_action <= cur.action;
          in_landmark_id <= cur.id;
          in_coord_x <= cur.x;
          in_coord_y <= cur.y;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_matches.size() == 0) begin
        $error("result with no item outstanding: status %0d id %0h dist %0h",
               out_status, out_match_id, out_best_distance_sq);
        fails++;
      end else begin
        seen = expected_matches.pop_front();
        if (out_status !== seen.status) begin
          $error("status: expected %0d, got %0d", seen.status, out_status);
          fails++;
        end
        if (out_match_id !== seen.id) begin
          $error("match_id: expected %0h, got %0h", seen.id, out_match_id);
          fails++;
        end
        if (out_best_distance_sq !== seen.dsq) begin
          $error("best_distance_sq: expected %0h, got %0h",
                 seen.dsq, out_best_distance_sq);
          fails++;
        end
        if (seen.status == ST_NO_MATCH) n_empty++;
        else if (seen.status == ST_FULL) n_dropped++;
        else if (seen.dsq != 0 || seen.id != 0) n_matched++;
      end
    end
  end

  initial begin
    int idles [4];
    idles = '{0, 63, 0, 31};
    phase_idle = 0;
    add(ACT_QUERY, 16'h0000, 24'd0, 24'd0);
    add(ACT_UNUSED, 16'h0000, 24'd0, 24'd0);
    add(ACT_LOAD, 16'h0000, C_MAX, C_MAX);
    add(ACT_QUERY, 16'hFFFF, C_MIN, C_MIN);
    add(ACT_QUERY, 16'h0000, C_MAX, C_MAX);
    add(ACT_LOAD, 16'hFFFF, C_MIN, C_MIN);
    add(ACT_QUERY, 16'h0000, 24'd0, 24'd0);
    add(ACT_QUERY, 16'h0000, -24'sd1, -24'sd1);
    add(ACT_CLEAR, 16'h0000, 24'd0, 24'd0);
    add(ACT_QUERY, 16'h0000, 24'd0, 24'd0);
    add(ACT_LOAD, 16'h1111, 24'sd100, 24'sd0);
    add(ACT_LOAD, 16'h2222, -24'sd100, 24'sd0);
    add(ACT_QUERY, 16'h0000, 24'd0, 24'd0);
    add(ACT_LOAD, 16'h3333, 24'sd0, 24'sd100);
    add(ACT_QUERY, 16'h0000, 24'd0, 24'd0);
    add(ACT_QUERY, 16'h0000, 24'sd0, 24'sd1);
    add(ACT_LOAD, 16'hA5A5, 24'sd100, 24'sd0);
    add(ACT_QUERY, 16'h0000, 24'sd101, 24'sd0);
    add(ACT_UNUSED, 16'hFFFF, C_MIN, C_MAX);
    add(ACT_QUERY, 16'hFFFF, C_MIN, C_MAX);
    add(ACT_CLEAR, 16'hFFFF, C_MAX, C_MIN);
    add_hold();
    for (int p = 0; p < 4; p++) begin
      phase_idle = idles[p];
      while (pending.size() < 22 + (p + 1) * 382) gen_sequence();
      add_hold();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start) @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d items checked: %0d nearest matches, %0d empty-table queries, %0d dropped loads",
             n_items, n_matched, n_empty, n_dropped);
    $display("idle phases 0/63/0/31 percent, with a full drain between phases");
    if (fails == 0) begin
      $display("nearest_landmark_matcher_tb passed");
    end else begin
      $display("nearest_landmark_matcher_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("nearest_landmark_matcher_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
